// ===== hw/rtl/eibr_pkg.sv =====
// eibr_pkg: shared widths and constants for edge_interval_bit_recovery
// depends on nothing; imported by the top level
package eibr_pkg;

  localparam int unsigned STAMP_W        = 32;  // edge timestamp width
  localparam int unsigned PERIOD_W       = 16;  // bit period register width
  localparam int unsigned RUN_W          = 4;   // run_length field width
  localparam int unsigned RUN_SHOWN_MAX  = 15;  // largest value run_length holds
  localparam int unsigned MAX_RUN_DEF    = 15;  // default run cap
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  // divider: numerator 2*interval + period, denominator 2*period
  localparam int unsigned NUM_W  = STAMP_W + 2;
  localparam int unsigned DEN_W  = PERIOD_W + 1;
  localparam int unsigned REM_W  = DEN_W + 1;
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

endpackage

// ===== hw/rtl/edge_interval_bit_recovery.sv =====
// edge_interval_bit_recovery: turns edge timestamps into runs of recovered bits
// an accepted edge is registered, checked in ST_CALC, then divided in ST_DIV (skipped
// when the period is zero), then one bit per cycle as the sink takes them; one edge in flight at a time,
// so no new edge is taken until its run is out; ST_DIV is a bit-serial restoring divider.
// reset (rst_ni low, async): stored timestamp cleared, period back to 1000, no output
module edge_interval_bit_recovery
  import eibr_pkg::*;
#(
  parameter int unsigned MAX_RUN = MAX_RUN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration: bit_period_us
  input  logic                  cfg_we_i,
  input  logic [PERIOD_W-1:0]   cfg_wdata_i,
  // edge requests
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] edge_time, [32] level_now
  // recovered bits
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] bit_value, [4:1] run_length
  output logic                  m_axis_tlast    // last_of_run
);

  localparam int unsigned RW = $clog2(MAX_RUN + 1);
  localparam int unsigned QW = RW + 1;
  localparam int unsigned CW = (RW > RUN_W) ? RW : RUN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [PERIOD_W-1:0]  period_q, period_d;
  logic [STAMP_W-1:0]   last_q, last_d;
  logic [STAMP_W-1:0]   stamp_q, stamp_d;
  logic                 level_q, level_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [QW-1:0]        quo_q, quo_d;
  logic                 ovf_q, ovf_d;
  logic [DCNT_W-1:0]    dcnt_q, dcnt_d;
  logic [RW-1:0]        left_q, left_d;
  logic                 ovalid_q, ovalid_d;
  logic                 obit_q, obit_d;
  logic [RUN_W-1:0]     olen_q, olen_d;
  logic                 olast_q, olast_d;

  always_comb begin
    logic [STAMP_W-1:0] interval;
    logic               spurious;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   den;
    logic               qbit;
    logic [QW-1:0]      quo_nx;
    logic               ovf_nx;
    logic [RW-1:0]      run;
    logic [CW-1:0]      run_ext;
    logic               start;

    state_d  = state_q;
    period_d = period_q;
    last_d   = last_q;
    stamp_d  = stamp_q;
    level_d  = level_q;
    num_d    = num_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    ovf_d    = ovf_q;
    dcnt_d   = dcnt_q;
    left_d   = left_q;
    ovalid_d = ovalid_q;
    obit_d   = obit_q;
    olen_d   = olen_q;
    olast_d  = olast_q;

    interval = stamp_q - last_q;
    spurious = (interval[STAMP_W-1:PERIOD_W] == '0) &&
               ({1'b0, interval[PERIOD_W-1:0], 1'b0} < {2'b00, period_q});
    den      = {1'b0, period_q, 1'b0};
    rem_sh   = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
    qbit     = (rem_sh >= den);
    quo_nx   = {quo_q[QW-2:0], qbit};
    ovf_nx   = ovf_q | quo_q[QW-1];
    run      = RW'(MAX_RUN);
    run_ext  = '0;
    start    = 1'b0;

    if (cfg_we_i) begin
      period_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          stamp_d = s_axis_tdata[STAMP_W-1:0];
          level_d = s_axis_tdata[STAMP_W];
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (period_q == '0) begin
          // zero period: every edge is a full-length run
          start = 1'b1;
        end else if (spurious) begin
          state_d = ST_IDLE;
        end else begin
          num_d  = {1'b0, interval, 1'b0} + NUM_W'(period_q);
          rem_d  = '0;
          quo_d  = '0;
          ovf_d  = 1'b0;
          dcnt_d = DCNT_W'(NUM_W);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = qbit ? (rem_sh - den) : rem_sh;
        num_d  = {num_q[NUM_W-2:0], 1'b0};
        quo_d  = quo_nx;
        ovf_d  = ovf_nx;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCNT_W'(1)) begin
          start = 1'b1;
          // saturate the quotient at the run cap
          if (!ovf_nx && (quo_nx <= QW'(MAX_RUN))) begin
            run = quo_nx[RW-1:0];
          end
        end
      end
      ST_EMIT: begin
        if (m_axis_tready) begin
          if (left_q == RW'(1)) begin
            ovalid_d = 1'b0;
            olast_d  = 1'b0;
            state_d  = ST_IDLE;
          end else begin
            left_d  = left_q - 1'b1;
            olast_d = (left_q == RW'(2));
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (start) begin
      run_ext  = CW'(run);
      last_d   = stamp_q;
      left_d   = run;
      ovalid_d = 1'b1;
      obit_d   = ~level_q;
      olen_d   = (run_ext > CW'(RUN_SHOWN_MAX)) ? RUN_W'(RUN_SHOWN_MAX) : RUN_W'(run_ext);
      olast_d  = (run == RW'(1));
      state_d  = ST_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      period_q <= PERIOD_RESET;
      last_q   <= '0;
      left_q   <= '0;
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
      obit_q   <= 1'b0;
      olen_q   <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      period_q <= period_d;
      last_q   <= last_d;
      left_q   <= left_d;
      dcnt_q   <= dcnt_d;
      ovalid_q <= ovalid_d;
      obit_q   <= obit_d;
      olen_q   <= olen_d;
      olast_q  <= olast_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
    level_q <= level_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    ovf_q   <= ovf_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RUN_W - 1){1'b0}}, olen_q, obit_q};

  // output only while a run is being emitted
  a_valid_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (state_q == ST_EMIT))
    else $error("output valid outside emit state");

  // tlast marks exactly the final bit of the run
  a_last_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (left_q == RW'(1))))
    else $error("tlast does not match remaining bit count");

  // no new edge taken while a run is still pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !m_axis_tvalid)
    else $error("edge accepted during emit");

  // the run ends when its last bit is taken
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output still valid after last bit");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for edge_interval_bit_recovery, edge requests in, recovered bits out
// a directed table, then random phases over several bit periods; every recovered bit is scored against the
// table's expected run or an in-bench run predictor. depends on eibr_pkg and the top level only
module tb_top;
  import eibr_pkg::*;

  localparam int unsigned RUN_CAP   = MAX_RUN_DEF;
  localparam int unsigned SETTLE_CY = 60;   // more than the edge latency through the divider
  localparam int unsigned N_ROWS    = 23;
  localparam int unsigned N_PHASES  = 7;
  localparam int unsigned PHASE_LEN = 43;

  typedef struct packed {
    logic       bit_v;
    logic [3:0] run_len;
    logic       last_of_run;
  } recovered_bit_t;

  // one directed edge: optional period write first, stamp absolute or relative to the stored one
  typedef struct {
    bit          wr_cfg;
    logic [15:0] cfg_val;
    bit          is_abs;
    logic [31:0] stamp_val;
    logic        lvl;
    bit          typed;
    int          n_exp;
  } edge_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [PERIOD_W-1:0]   cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [31:0] edge_time, [32] level_now
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] bit_value, [4:1] run_length
  logic                  m_axis_tlast;   // last_of_run

  bit             calm = 1'b0;   // no idling on either side while set
  int unsigned    fail_cnt = 0;
  recovered_bit_t bits_due[$];

  // predictor state
  logic [31:0]         pred_last_stamp;
  logic [PERIOD_W-1:0] pred_period;

  edge_row_t edge_rows [N_ROWS] = '{
    // period 1000 after reset
    '{1'b0, 16'd0,     1'b1, 32'h0000_0000, 1'b1, 1'b1, 0},   // first edge, zero interval
    '{1'b0, 16'd0,     1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 15},  // long run from zero
    '{1'b0, 16'd0,     1'b0, 32'd999,       1'b1, 1'b1, 1},   // stamp wraps forward
    '{1'b0, 16'd0,     1'b0, 32'd499,       1'b0, 1'b1, 0},   // just under half a bit
    '{1'b0, 16'd0,     1'b0, 32'd500,       1'b0, 1'b1, 1},   // exactly half a bit
    '{1'b0, 16'd0,     1'b0, 32'd2499,      1'b1, 1'b1, 2},
    '{1'b0, 16'd0,     1'b0, 32'd2500,      1'b0, 1'b1, 3},   // half rounds up
    '{1'b0, 16'd0,     1'b0, 32'd15000,     1'b1, 1'b1, 15},
    '{1'b0, 16'd0,     1'b0, 32'd14499,     1'b0, 1'b1, 14},
    '{1'b0, 16'd0,     1'b0, 32'hFFFF_FC18, 1'b1, 1'b1, 15},  // stamp earlier than stored
    '{1'b0, 16'd0,     1'b1, 32'h0000_0000, 1'b0, 1'b0, 0},
    '{1'b0, 16'd0,     1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0, 0},
    '{1'b0, 16'd0,     1'b1, 32'h5555_5555, 1'b0, 1'b0, 0},
    // zero period: everything accepted, full runs
    '{1'b1, 16'd0,     1'b0, 32'd0,         1'b1, 1'b1, 15},
    '{1'b1, 16'd0,     1'b0, 32'd1,         1'b0, 1'b1, 15},
    // shortest period
    '{1'b1, 16'd1,     1'b0, 32'd0,         1'b1, 1'b1, 0},
    '{1'b0, 16'd0,     1'b0, 32'd1,         1'b0, 1'b1, 1},
    '{1'b0, 16'd0,     1'b0, 32'd7,         1'b1, 1'b1, 7},
    '{1'b0, 16'd0,     1'b0, 32'd16,        1'b0, 1'b1, 15},
    // longest period
    '{1'b1, 16'd65535, 1'b0, 32'd32767,     1'b1, 1'b1, 0},
    '{1'b0, 16'd0,     1'b0, 32'd32768,     1'b0, 1'b1, 1},
    '{1'b0, 16'd0,     1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 15},
    '{1'b0, 16'd0,     1'b0, 32'd196605,    1'b0, 1'b1, 3}
  };

  edge_interval_bit_recovery #(
    .MAX_RUN(RUN_CAP)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // bits recovered for an edge at this stamp, 0 when the edge is spurious
  function automatic int unsigned recover_run(input logic [31:0] stamp);
    logic [63:0] ivl;
    logic [63:0] per;
    logic [63:0] run;
    ivl = {32'd0, 32'(stamp - pred_last_stamp)};
    per = {48'd0, pred_period};
    if (per == 64'd0) return RUN_CAP;
    if (2 * ivl < per) return 0;
    run = (2 * ivl + per) / (2 * per);
    if (run > 64'(RUN_CAP)) run = 64'(RUN_CAP);
    return int'(run);
  endfunction

  function automatic void queue_run(input int unsigned n, input logic bit_v);
    recovered_bit_t rb;
    for (int unsigned k = 0; k < n; k++) begin
      rb.bit_v       = bit_v;
      rb.run_len     = (n > RUN_SHOWN_MAX) ? 4'(RUN_SHOWN_MAX) : 4'(n);
      rb.last_of_run = (k + 1 == n);
      bits_due.push_back(rb);
    end
  endfunction

  // present one edge request, predict its run once it is taken
  task automatic send_edge(input logic [31:0] stamp, input logic lvl, input bit typed,
                           input int unsigned n_typed);
    int unsigned n;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, lvl, stamp};
    do @(posedge clk_i); while (!s_axis_tready);
    n = recover_run(stamp);
    if (n != 0) begin
      pred_last_stamp = stamp;
    end
    queue_run(typed ? n_typed : n, ~lvl);
  endtask

  // stop sending, let every due bit come out and a spurious edge finish
  task automatic drain_bits();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (bits_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CY) @(posedge clk_i);
  endtask

  task automatic set_period(input logic [PERIOD_W-1:0] per);
    drain_bits();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= per;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_period = per;
  endtask

  // sink side stalls
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk_i) begin
    recovered_bit_t rb;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (bits_due.size() == 0) begin
        $error("recovered bit with none due: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        fail_cnt++;
      end else begin
        rb = bits_due.pop_front();
        if (m_axis_tdata[0] !== rb.bit_v) begin
          $error("bit_value expected %b actual %b", rb.bit_v, m_axis_tdata[0]);
          fail_cnt++;
        end
        if (m_axis_tdata[4:1] !== rb.run_len) begin
          $error("run_length expected %0d actual %0d", rb.run_len, m_axis_tdata[4:1]);
          fail_cnt++;
        end
        if (m_axis_tlast !== rb.last_of_run) begin
          $error("last_of_run expected %b actual %b", rb.last_of_run, m_axis_tlast);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    logic [PERIOD_W-1:0] phase_per [N_PHASES];
    logic [63:0]         delta;
    logic [63:0]         per;
    logic [31:0]         stamp;
    int unsigned         pick;
    int unsigned         k;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    pred_last_stamp = '0;
    pred_period     = PERIOD_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (edge_rows[i]) begin
      if (edge_rows[i].wr_cfg) set_period(edge_rows[i].cfg_val);
      stamp = edge_rows[i].is_abs ? edge_rows[i].stamp_val
                                  : 32'(pred_last_stamp + edge_rows[i].stamp_val);
      send_edge(stamp, edge_rows[i].lvl, edge_rows[i].typed, edge_rows[i].n_exp);
    end

    phase_per[0] = PERIOD_RESET;
    phase_per[1] = 16'd1;
    phase_per[2] = 16'(1 + $urandom_range(1, 39));
    phase_per[3] = 16'd65535;
    phase_per[4] = 16'd0;
    phase_per[5] = 16'($urandom_range(41, 65534));
    phase_per[6] = 16'($urandom_range(1, 65535));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_period(phase_per[ph]);
      calm = (ph == 2);
      per  = {48'd0, pred_period};
      for (int n = 0; n < PHASE_LEN; n++) begin
        pick = $urandom_range(0, 99);
        k    = $urandom_range(1, 17);
        if (pick < 70) begin
          // edge near a whole number of bits, jitter within half a bit
          delta = 64'(k) * per + 64'($urandom_range(0, 32'(per))) - per / 2;
          stamp = 32'(pred_last_stamp + delta[31:0]);
        end else if (pick < 80) begin
          // glitch inside half a bit
          delta = (per == 0) ? 64'd0 : 64'($urandom_range(0, 32'((per - 1) / 2)));
          stamp = 32'(pred_last_stamp + delta[31:0]);
        end else if (pick < 90) begin
          stamp = $urandom();
        end else begin
          // right on the rounding boundary
          delta = 64'(k) * per + per / 2;
          stamp = 32'(pred_last_stamp + delta[31:0]);
        end
        send_edge(stamp, 1'($urandom_range(0, 1)), 1'b0, 0);
      end
      calm = 1'b0;
    end

    drain_bits();
    if (fail_cnt == 0 && bits_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
